// ===== src/sqrot_pkg.sv =====
// Package for the square matrix rotator: sizes, operation codes and the
// transaction structs shared by the front, queue, back and top level.
// No dependencies.
package sqrot_pkg;

  localparam int MAX_SIDE  = 64;
  localparam int WORD_BITS = 32;
  localparam int SIDE_W    = 7;                       // matrix_size register
  localparam int IDX_W     = $clog2(MAX_SIDE);        // row / column index
  localparam int POS_W     = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int ADDR_W    = POS_W + 1;               // bank bit + position
  localparam int PROD_W    = 2 * SIDE_W;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic [WORD_BITS-1:0] element;
  } in_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] element_out;
    logic [IDX_W-1:0]     out_first_index;
    logic [IDX_W-1:0]     out_second_index;
    logic                 end_of_frame;
  } out_item_t;

  // One bank command: an optional write and an optional read.
  typedef struct packed {
    logic                 do_write;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 do_read;
    logic [ADDR_W-1:0]    raddr;
    logic [IDX_W-1:0]     row;
    logic [IDX_W-1:0]     col;
    logic                 last;
  } bank_cmd_t;

endpackage

// ===== src/sqrot_front.sv =====
// Front end of the rotator: holds the size register and all frame counters,
// turns each accepted push, or any accepted item while a frame waits, into a bank command. Depends on sqrot_pkg.
module sqrot_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  sqrot_pkg::in_item_t          item,
  input  logic                         cfg_we,
  input  logic [sqrot_pkg::SIDE_W-1:0] cfg_size,
  output logic                         cmd_push,
  output sqrot_pkg::bank_cmd_t         cmd
);
  import sqrot_pkg::*;

  logic [SIDE_W-1:0] size_r, size_nxt;
  logic [POS_W-1:0]  last_pos_r, last_pos_nxt;   // n*n - 1
  logic [POS_W-1:0]  base_r, base_nxt;           // (n-1)*n, source of row 0
  logic [POS_W-1:0]  wpos_r, wpos_nxt;
  logic [POS_W-1:0]  rsrc_r, rsrc_nxt;
  logic [IDX_W-1:0]  ra_r, ra_nxt;
  logic [IDX_W-1:0]  rb_r, rb_nxt;
  logic              wsel_r, wsel_nxt;
  logic              waiting_r, waiting_nxt;

  logic [SIDE_W-1:0] clamped;
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  nm1;
  logic              is_push;
  logic              rd_last;
  logic              wr_done;

  always_comb begin
    if (cfg_size == '0) begin
      clamped = SIDE_W'(1);
    end else if (cfg_size > SIDE_W'(MAX_SIDE)) begin
      clamped = SIDE_W'(MAX_SIDE);
    end else begin
      clamped = cfg_size;
    end
  end

  assign prod         = PROD_W'(clamped) * PROD_W'(clamped);
  assign last_pos_nxt = cfg_we ? POS_W'(prod - PROD_W'(1)) : last_pos_r;
  assign base_nxt     = cfg_we ? POS_W'(prod - PROD_W'(clamped)) : base_r;
  assign size_nxt     = cfg_we ? clamped : size_r;

  assign nm1     = IDX_W'(size_r - SIDE_W'(1));
  assign is_push = (item.operation == OP_PUSH);
  assign rd_last = (ra_r == nm1) && (rb_r == nm1);
  assign wr_done = (wpos_r == last_pos_r);

  always_comb begin
    wpos_nxt    = wpos_r;
    rsrc_nxt    = rsrc_r;
    ra_nxt      = ra_r;
    rb_nxt      = rb_r;
    wsel_nxt    = wsel_r;
    waiting_nxt = waiting_r;
    if (cfg_we) begin
      // drop partial and waiting frames, keep the bank select
      wpos_nxt    = '0;
      ra_nxt      = '0;
      rb_nxt      = '0;
      rsrc_nxt    = base_nxt;
      waiting_nxt = 1'b0;
    end else if (accept) begin
      if (waiting_r) begin
        if (rd_last) begin
          waiting_nxt = 1'b0;
          ra_nxt      = '0;
          rb_nxt      = '0;
        end else if (rb_r == nm1) begin
          rb_nxt   = '0;
          ra_nxt   = ra_r + IDX_W'(1);
          rsrc_nxt = base_r + POS_W'(ra_r) + POS_W'(1);
        end else begin
          rb_nxt   = rb_r + IDX_W'(1);
          rsrc_nxt = rsrc_r - POS_W'(size_r);
        end
      end
      if (is_push) begin
        if (wr_done) begin
          // frame complete: swap banks and start draining it
          wpos_nxt    = '0;
          wsel_nxt    = ~wsel_r;
          waiting_nxt = 1'b1;
          ra_nxt      = '0;
          rb_nxt      = '0;
          rsrc_nxt    = base_r;
        end else begin
          wpos_nxt = wpos_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r     <= SIDE_W'(MAX_SIDE);
      last_pos_r <= POS_W'(MAX_SIDE * MAX_SIDE - 1);
      base_r     <= POS_W'((MAX_SIDE - 1) * MAX_SIDE);
      wpos_r     <= '0;
      rsrc_r     <= POS_W'((MAX_SIDE - 1) * MAX_SIDE);
      ra_r       <= '0;
      rb_r       <= '0;
      wsel_r     <= 1'b0;
      waiting_r  <= 1'b0;
    end else begin
      size_r     <= size_nxt;
      last_pos_r <= last_pos_nxt;
      base_r     <= base_nxt;
      wpos_r     <= wpos_nxt;
      rsrc_r     <= rsrc_nxt;
      ra_r       <= ra_nxt;
      rb_r       <= rb_nxt;
      wsel_r     <= wsel_nxt;
      waiting_r  <= waiting_nxt;
    end
  end

  assign cmd_push     = accept && (is_push || waiting_r);
  assign cmd.do_write = is_push;
  assign cmd.waddr    = {wsel_r, wpos_r};
  assign cmd.wdata    = item.element;
  assign cmd.do_read  = waiting_r;
  assign cmd.raddr    = {~wsel_r, rsrc_r};
  assign cmd.row      = ra_r;
  assign cmd.col      = rb_r;
  assign cmd.last     = rd_last;

  a_src_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    waiting_r |-> rsrc_r <= last_pos_r)
    else $error("read source beyond frame");

  a_coords_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    waiting_r |-> (SIDE_W'(ra_r) < size_r) && (SIDE_W'(rb_r) < size_r))
    else $error("read coordinates outside matrix");

  a_drain_ends_with_fill: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !cfg_we && is_push && wr_done && waiting_r |-> rd_last)
    else $error("frame completed while previous frame still draining");

  a_no_write_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (wpos_r == '0) && !waiting_r)
    else $error("size write did not restart frame");

endmodule

// ===== src/sqrot_queue.sv =====
// Two-entry command queue between front and back of the rotator.
// Depends on sqrot_pkg.
module sqrot_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sqrot_pkg::bank_cmd_t push_cmd,
  input  logic                 pop,
  output sqrot_pkg::bank_cmd_t head,
  output logic                 empty,
  output logic                 full
);
  import sqrot_pkg::*;

  bank_cmd_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign empty   = (count_r == 2'd0);
  assign full    = (count_r == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  assign wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
  assign rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2)
    else $error("queue count out of range");

  a_ptrs_track_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

endmodule

// ===== src/sqrot_back.sv =====
// Back end of the rotator: the two frame banks and the result register.
// Executes one bank command per cycle. Depends on sqrot_pkg.
module sqrot_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  sqrot_pkg::bank_cmd_t cmd,
  output logic                 res_valid,
  output sqrot_pkg::out_item_t res
);
  import sqrot_pkg::*;

  localparam int DEPTH = 2 ** ADDR_W;

  logic [WORD_BITS-1:0] bank_mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_r;
  logic [IDX_W-1:0]     row_r;
  logic [IDX_W-1:0]     col_r;
  logic                 last_r;
  logic                 vld_r, vld_nxt;

  assign vld_nxt = cmd_valid && cmd.do_read;

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd.do_write) begin
      bank_mem[cmd.waddr] <= cmd.wdata;
    end
    if (vld_nxt) begin
      rdata_r <= bank_mem[cmd.raddr];
      row_r   <= cmd.row;
      col_r   <= cmd.col;
      last_r  <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign res_valid            = vld_r;
  assign res.element_out      = rdata_r;
  assign res.out_first_index  = row_r;
  assign res.out_second_index = col_r;
  assign res.end_of_frame     = last_r;

  a_banks_apart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid && cmd.do_write && cmd.do_read
      |-> cmd.waddr[ADDR_W-1] != cmd.raddr[ADDR_W-1])
    else $error("read and write hit the same bank");

  a_last_on_corner: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && last_r |-> row_r == col_r)
    else $error("end of frame away from the corner");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> $past(cmd_valid && cmd.do_read))
    else $error("result strobe without a read");

endmodule

// ===== src/square_matrix_rotate_core.sv =====
// Top level of the 90-degree square matrix rotator (ping-pong banks).
// Depends on sqrot_pkg, sqrot_front, sqrot_queue, sqrot_back.
//
//   channel | ports                          | handshake
//   --------+--------------------------------+-------------------------------
//   input   | start, busy, in_data           | taken when start && !busy
//   result  | out_valid, out_data            | one-cycle strobe, no stall
//   config  | cfg_valid, cfg_ready, cfg_data | written when valid && ready
//
// One item per cycle while busy is low; a result passes the command queue
// stage and then the registered bank read.
// Reset: sync active-low; size returns to 64, no frame waiting. Bank
// contents are not cleared, so no clearing pass is run.
// busy only rises if the queue fills; the back end pops whenever it is not empty.
// cfg_ready is high while the command queue is empty and start is low.
module square_matrix_rotate_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  sqrot_pkg::in_item_t          in_data,
  output logic                         out_valid,
  output sqrot_pkg::out_item_t         out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sqrot_pkg::SIDE_W-1:0] cfg_data
);
  import sqrot_pkg::*;

  logic      accept;
  logic      cfg_we;
  logic      cmd_push;
  bank_cmd_t cmd;
  bank_cmd_t head;
  logic      q_empty;
  logic      q_full;

  assign busy      = q_full;
  assign accept    = start && !q_full;
  // hold a size write while a transaction is offered or still queued
  assign cfg_ready = q_empty && !start;
  assign cfg_we    = cfg_valid && cfg_ready;

  sqrot_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_data),
    .cfg_we   (cfg_we),
    .cfg_size (cfg_data),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  sqrot_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd),
    .pop      (!q_empty),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  sqrot_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!q_empty),
    .cmd       (head),
    .res_valid (out_valid),
    .res       (out_data)
  );

endmodule
